FILE: rtl/msbp_pkg.sv
package msbp_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_REWIND = 2'd3;

  localparam logic [2:0] KIND_BOOL = 3'd0;
  localparam logic [2:0] KIND_U4   = 3'd1;
  localparam logic [2:0] KIND_S4   = 3'd2;
  localparam logic [2:0] KIND_B8   = 3'd3;
  localparam logic [2:0] KIND_B16  = 3'd4;
  localparam logic [2:0] KIND_B24  = 3'd5;
  localparam logic [2:0] KIND_B32  = 3'd6;

  // Control for the byte-digit shift register
  typedef struct packed {
    logic       load;      // take a left-justified field, aligned by off
    logic [2:0] off;
    logic       push_out;  // write: advance one byte toward the store
    logic       push_in;   // read: shift in one byte from the store
    logic [2:0] tail;      // read: bits after the field in the last byte
    logic [2:0] kind;
  } msbp_shift_ctl_t;

  function automatic logic [5:0] kind_width(input logic [2:0] kind);
    logic [5:0] w;
    begin
      case (kind)
        KIND_BOOL: w = 6'd1;
        KIND_U4:   w = 6'd4;
        KIND_S4:   w = 6'd4;
        KIND_B8:   w = 6'd8;
        KIND_B16:  w = 6'd16;
        KIND_B24:  w = 6'd24;
        KIND_B32:  w = 6'd32;
        default:   w = 6'd0;
      endcase
      return w;
    end
  endfunction

  // Put the field bits at the top of a 32-bit word, MSB first
  function automatic logic [31:0] left_justify(input logic [2:0] kind,
                                               input logic [31:0] value);
    logic [31:0] r;
    logic [7:0]  lb;
    logic        in_range;
    begin
      lb = value[7:0];
      // signed byte must lie in -7 .. 8
      in_range = (lb <= 8'd8) || (lb >= 8'hF9);
      case (kind)
        KIND_BOOL: r = {(|value), 31'd0};
        KIND_U4:   r = {value[3:0], 28'd0};
        KIND_S4:   r = in_range ? {lb[3:0], 28'd0} : 32'd0;
        KIND_B8:   r = {value[7:0], 24'd0};
        KIND_B16:  r = {value[15:0], 16'd0};
        KIND_B24:  r = {value[23:0], 8'd0};
        KIND_B32:  r = value;
        default:   r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // Keep the low field bits of a right-aligned word; sign extend int4
  function automatic logic [31:0] narrow_field(input logic [2:0] kind,
                                               input logic [31:0] x);
    logic [31:0] r;
    begin
      case (kind)
        KIND_BOOL: r = {31'd0, x[0]};
        KIND_U4:   r = {28'd0, x[3:0]};
        KIND_S4:   r = {{28{x[3]}}, x[3:0]};
        KIND_B8:   r = {24'd0, x[7:0]};
        KIND_B16:  r = {16'd0, x[15:0]};
        KIND_B24:  r = {8'd0, x[23:0]};
        KIND_B32:  r = x;
        default:   r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: rtl/msbp_ram.sv
module msbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/msbp_shifter.sv
module msbp_shifter (
  input  logic                     clk,
  input  msbp_pkg::msbp_shift_ctl_t ctl,
  input  logic [31:0]              ljust,
  input  logic [7:0]               din,
  output logic [7:0]               top_byte,
  output logic [31:0]              field_out
);
  import msbp_pkg::*;

  logic [39:0] sr;
  logic [39:0] merged;
  logic [39:0] aligned;

  assign merged   = {sr[31:0], din};
  assign aligned  = merged >> ctl.tail;
  assign top_byte = sr[39:32];
  assign field_out = narrow_field(ctl.kind, aligned[31:0]);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sr <= {ljust, 8'h00} >> ctl.off;
    end else if (ctl.push_out) begin
      sr <= {sr[31:0], 8'h00};
    end else if (ctl.push_in) begin
      sr <= merged;
    end
  end

endmodule

FILE: rtl/msb_first_bit_field_packer.sv
// MSB-first bit-field packer over a byte store.
// Command channel: operation, field_kind and value are taken at a rising edge
// with start high and busy low. Operations: write field, read field, clear
// store, rewind read cursor.
// Result channel: done pulses for one cycle with read_value, byte_length and
// overflow; the receiver cannot hold it off, and done never waits on it.
// Config channel: cfg_data loads max_len when cfg_valid and cfg_ready are high;
// write it only while no command is in flight.
// Transfer: a write or read that touches k bytes (1 to 5) runs a byte-serial
// transfer through the single RAM read-modify-write path, one byte per cycle;
// the next command can be taken in the done cycle. Clear, rewind, an
// overflowing access and an unused field kind skip the transfer, and done
// follows in the cycle after the accept.
// Reset: the store reads as zero (per-byte valid bits cleared at once, as on a
// clear command), both cursors rewind, max_len goes to 255. No clearing pass.
module msb_first_bit_field_packer #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [2:0]  field_kind,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] read_value,
  output logic [8:0]  byte_length,
  output logic        overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import msbp_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int BIT_W  = $clog2(BUFFER_BYTES * 8 + 1);

  typedef enum logic {S_IDLE, S_XFER} state_t;

  state_t            state;
  logic [7:0]        max_len;
  logic [BIT_W-1:0]  wbit;
  logic [BIT_W-1:0]  rbit;
  logic              is_read_q;
  logic [2:0]        kind_q;
  logic [ADDR_W-1:0] base_q;
  logic [2:0]        k_q;
  logic [2:0]        tail_q;
  logic [2:0]        cnt;
  logic [BUFFER_BYTES-1:0] vld;
  logic              byte_vld;

  logic              accept;
  logic [BIT_W-1:0]  start_bit;
  logic [5:0]        n;
  logic [BIT_W:0]    new_bit;
  logic [BIT_W:0]    end_sum;
  logic [8:0]        cap;
  logic              fits;
  logic [2:0]        off;
  logic [6:0]        span;
  logic              clear_hit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        rbyte;
  logic              proc;
  logic              last;

  msbp_shift_ctl_t   sctl;
  logic [7:0]        top_byte;
  logic [31:0]       field_out;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign clear_hit = accept && (operation == OP_CLEAR);

  // Cursor arithmetic for the command on the port
  assign start_bit = (operation == OP_READ) ? rbit : wbit;
  assign n         = kind_width(field_kind);
  assign new_bit   = (BIT_W+1)'(start_bit) + (BIT_W+1)'(n);
  assign end_sum   = new_bit + (BIT_W+1)'(7);
  assign cap       = (9'(max_len) > 9'(BUFFER_BYTES)) ? 9'(BUFFER_BYTES) : 9'(max_len);
  assign fits      = (9'(end_sum >> 3) <= cap);
  assign off       = start_bit[2:0];
  assign span      = 7'(off) + 7'(n);

  assign byte_length = 9'(({1'b0, wbit} + (BIT_W+1)'(7)) >> 3);

  // Byte-serial transfer: read byte cnt, merge byte cnt-1
  assign proc      = (state == S_XFER) && (cnt != 3'd0);
  assign last      = (state == S_XFER) && (cnt == k_q);
  assign ram_re    = (state == S_XFER) && (cnt < k_q);
  assign ram_raddr = base_q + ADDR_W'(cnt);
  assign ram_we    = proc && !is_read_q;
  assign ram_waddr = base_q + ADDR_W'(cnt - 3'd1);
  assign rbyte     = byte_vld ? ram_rdata : 8'h00;
  assign ram_wdata = rbyte | top_byte;

  always_comb begin
    sctl.load     = accept && (operation == OP_WRITE);
    sctl.off      = off;
    sctl.push_out = proc && !is_read_q;
    sctl.push_in  = proc && is_read_q;
    sctl.tail     = tail_q;
    sctl.kind     = kind_q;
  end

  msbp_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msbp_shifter u_shifter (
    .clk       (clk),
    .ctl       (sctl),
    .ljust     (left_justify(field_kind, value)),
    .din       (rbyte),
    .top_byte  (top_byte),
    .field_out (field_out)
  );

  // Per-byte valid bits: an unwritten byte reads as zero
  always_ff @(posedge clk) begin
    if (rst || clear_hit) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[ram_waddr] <= 1'b1;
    end
    if (ram_re) begin
      byte_vld <= vld[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wbit     <= '0;
      rbit     <= '0;
      done     <= 1'b0;
      overflow <= 1'b0;
      cnt      <= 3'd0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            read_value <= 32'd0;
            overflow   <= 1'b0;
            is_read_q  <= (operation == OP_READ);
            kind_q     <= field_kind;
            base_q     <= start_bit[ADDR_W+2:3];
            k_q        <= 3'(span + 7'd7 >> 3);
            tail_q     <= 3'd0 - span[2:0];
            cnt        <= 3'd0;
            unique case (operation)
              OP_WRITE, OP_READ: begin
                if (n == 6'd0) begin
                  done <= 1'b1;
                end else if (!fits) begin
                  overflow <= 1'b1;
                  done     <= 1'b1;
                end else begin
                  if (operation == OP_READ) begin
                    rbit <= BIT_W'(new_bit);
                  end else begin
                    wbit <= BIT_W'(new_bit);
                  end
                  state <= S_XFER;
                end
              end
              OP_CLEAR: begin
                wbit <= '0;
                rbit <= '0;
                done <= 1'b1;
              end
              OP_REWIND: begin
                rbit <= '0;
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_XFER: begin
          cnt <= cnt + 3'd1;
          if (last) begin
            if (is_read_q) begin
              read_value <= field_out;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_we_in_xfer: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_XFER))
    else $error("store written outside a transfer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_XFER) |-> (cnt <= k_q) && (k_q != 3'd0))
    else $error("transfer counter out of range");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    clear_hit |=> (done && (byte_length == 9'd0)))
    else $error("clear did not rewind the write cursor");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (read_value == 32'd0))
    else $error("overflowing access returned data");

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import msbp_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] read_value;
    logic [8:0]  byte_length;
    logic        overflow;
  } packer_result_t;

  // Tracks the byte store and both cursors; holds the results still to come.
  class packer_tracker;
    logic [7:0]     store [256];
    int unsigned    wr_bit;
    int unsigned    rd_bit;
    logic [7:0]     cap;
    packer_result_t awaited [$];
    int unsigned    errors;

    function new();
      foreach (store[i]) store[i] = '0;
      wr_bit = 0;
      rd_bit = 0;
      cap = 8'd255;
      errors = 0;
    endfunction

    function int unsigned bits_of_kind(logic [2:0] kind);
      case (kind)
        KIND_BOOL: return 1;
        KIND_U4, KIND_S4: return 4;
        KIND_B8: return 8;
        KIND_B16: return 16;
        KIND_B24: return 24;
        KIND_B32: return 32;
        default: return 0;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function bit drained();
      return awaited.size() == 0;
    endfunction

    function void note_command(logic [1:0] op, logic [2:0] kind, logic [31:0] val);
      packer_result_t    r;
      int unsigned       n;
      logic [31:0]       bits;
      logic signed [7:0] s;
      n = bits_of_kind(kind);
      r = '0;
      bits = '0;
      case (op)
        OP_WRITE: if (n != 0) begin
          case (kind)
            KIND_BOOL: bits = {31'd0, |val};
            KIND_S4: begin
              s = val[7:0];
              // signed nibble outside -7..8 goes in as zero
              if (s <= 8 && s >= -7) bits = {28'd0, val[3:0]};
            end
            KIND_B32: bits = val;
            default: bits = val & ((32'd1 << n) - 32'd1);
          endcase
          if (((wr_bit + n + 7) >> 3) <= cap) begin
            for (int i = 0; i < n; i++) begin
              if (bits[n - 1 - i]) store[(wr_bit + i) >> 3][7 - ((wr_bit + i) & 7)] = 1'b1;
            end
            wr_bit += n;
          end else begin
            r.overflow = 1'b1;
          end
        end
        OP_READ: if (n != 0) begin
          if (((rd_bit + n + 7) >> 3) <= cap) begin
            for (int i = 0; i < n; i++) begin
              bits = {bits[30:0], store[(rd_bit + i) >> 3][7 - ((rd_bit + i) & 7)]};
            end
            rd_bit += n;
            if (kind == KIND_S4 && bits[3]) bits |= 32'hFFFF_FFF0;
            r.read_value = bits;
          end else begin
            r.overflow = 1'b1;
          end
        end
        OP_CLEAR: begin
          foreach (store[i]) store[i] = '0;
          wr_bit = 0;
          rd_bit = 0;
        end
        OP_REWIND: rd_bit = 0;
        default: ;
      endcase
      r.byte_length = 9'((wr_bit + 7) >> 3);
      awaited.push_back(r);
    endfunction

    task check_result(logic [31:0] rv, logic [8:0] len, logic ovf);
      packer_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %h %0d %b", rv, len, ovf));
        return;
      end
      want = awaited.pop_front();
      if (rv !== want.read_value)
        report_mismatch($sformatf("read_value %h, want %h", rv, want.read_value));
      if (len !== want.byte_length)
        report_mismatch($sformatf("byte_length %0d, want %0d", len, want.byte_length));
      if (ovf !== want.overflow)
        report_mismatch($sformatf("overflow %b, want %b", ovf, want.overflow));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = OP_WRITE;
  logic [2:0]  field_kind = KIND_BOOL;
  logic [31:0] value = '0;
  logic        done;
  logic [31:0] read_value;
  logic [8:0]  byte_length;
  logic        overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  packer_tracker tracker = new();
  int unsigned   sent = 0;
  int unsigned   burst_left = 0;

  msb_first_bit_field_packer i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .field_kind (field_kind),
    .value      (value),
    .done       (done),
    .read_value (read_value),
    .byte_length(byte_length),
    .overflow   (overflow),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(read_value, byte_length, overflow);
  end

  // Hold off new commands until every pending result beat has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (!tracker.drained());
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
      case ($urandom_range(0, 9))
        0: drain();
        1, 2, 3: ;
        default: begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      endcase
    end
    burst_left--;
  endtask

  task automatic send_command(input logic [1:0] op, input logic [2:0] kind,
                              input logic [31:0] val);
    pace();
    start <= 1'b1;
    operation <= op;
    field_kind <= kind;
    value <= val;
    do @(posedge clk); while (busy);
    tracker.note_command(op, kind, val);
    if (!((op == OP_WRITE || op == OP_READ) && kind == KIND_UNUSED)) sent++;
  endtask

  task automatic set_capacity(input logic [7:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.cap = cap;
  endtask

  function automatic logic [31:0] draw_value();
    logic [31:0] v;
    logic [7:0]  lb;
    v = $urandom;
    case ($urandom_range(0, 5))
      2: v = $urandom_range(0, 15);
      3: begin
        // low byte around the signed nibble limits
        lb = 8'($urandom_range(0, 20)) - 8'd10;
        v = {v[31:8], lb};
      end
      4: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      5: v = 32'd1 << $urandom_range(0, 31);
      default: ;
    endcase
    return v;
  endfunction

  // Clear most of the time, then write a run of fields, rewind, and read the same kinds back.
  task automatic run_record();
    logic [2:0]  kinds [8];
    int unsigned count;
    count = $urandom_range(1, 8);
    if ($urandom_range(0, 9) < 7) send_command(OP_CLEAR, 3'($urandom), $urandom);
    for (int i = 0; i < count; i++) begin
      kinds[i] = 3'($urandom_range(KIND_BOOL, KIND_B32));
      send_command(OP_WRITE, kinds[i], draw_value());
    end
    send_command(OP_REWIND, 3'($urandom), $urandom);
    for (int i = 0; i < count; i++) send_command(OP_READ, kinds[i], $urandom);
  endtask

  task automatic send_noise();
    logic [1:0]  op;
    logic [2:0]  kind;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    op = (pick < 8) ? OP_WRITE : (pick < 16) ? OP_READ : (pick < 18) ? OP_REWIND : OP_CLEAR;
    kind = ($urandom_range(0, 15) == 0) ? KIND_UNUSED : 3'($urandom_range(KIND_BOOL, KIND_B32));
    send_command(op, kind, draw_value());
  endtask

  initial begin
    logic [7:0]  caps [6];
    int unsigned phase_end;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_command(OP_WRITE, KIND_BOOL, 32'h0);
    send_command(OP_WRITE, KIND_BOOL, 32'h8000_0000);
    send_command(OP_WRITE, KIND_U4, 32'hFFFF_FFF5);
    send_command(OP_WRITE, KIND_S4, 32'h0000_0008);
    send_command(OP_WRITE, KIND_S4, 32'h0000_0009);
    send_command(OP_WRITE, KIND_S4, 32'h0000_00F9);
    send_command(OP_WRITE, KIND_S4, 32'h1234_56F8);
    send_command(OP_WRITE, KIND_B8, 32'hFFFF_FFFF);
    send_command(OP_WRITE, KIND_B16, 32'h0000_FFFF);
    send_command(OP_WRITE, KIND_B24, 32'h55AB_CDEF);
    send_command(OP_WRITE, KIND_B32, 32'hFFFF_FFFF);
    send_command(OP_WRITE, KIND_UNUSED, 32'hFFFF_FFFF);
    send_command(OP_READ, KIND_UNUSED, 32'h0);
    send_command(OP_READ, KIND_BOOL, 32'h0);
    send_command(OP_READ, KIND_BOOL, 32'h0);
    send_command(OP_READ, KIND_U4, 32'h0);
    repeat (4) send_command(OP_READ, KIND_S4, 32'h0);
    send_command(OP_READ, KIND_B8, 32'h0);
    send_command(OP_READ, KIND_B32, 32'h0);
    send_command(OP_REWIND, KIND_BOOL, 32'h0);
    // write cursor now sits beyond a one-byte capacity
    set_capacity(8'd1);
    send_command(OP_WRITE, KIND_B8, 32'h0000_005A);
    send_command(OP_CLEAR, KIND_B32, 32'h0);
    send_command(OP_WRITE, KIND_B8, 32'h0000_005A);
    send_command(OP_WRITE, KIND_BOOL, 32'h1);
    send_command(OP_READ, KIND_B16, 32'h0);
    send_command(OP_READ, KIND_B8, 32'h0);
    send_command(OP_READ, KIND_BOOL, 32'h0);

    caps[0] = 8'd255;
    caps[1] = 8'd1;
    caps[2] = 8'($urandom_range(2, 16));
    caps[3] = 8'($urandom_range(17, 254));
    caps[4] = 8'd255;
    caps[5] = 8'($urandom_range(1, 255));
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      phase_end = sent + 87;
      while (sent < phase_end) begin
        if ($urandom_range(0, 9) < 6) run_record();
        else send_noise();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.drained()) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msbp_pkg.sv
rtl/msbp_ram.sv
rtl/msbp_shifter.sv
rtl/msb_first_bit_field_packer.sv
bench/tb_top.sv
